FILE: hw/rtl/rwca_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwca_pkg
// Shared widths, constants, types and helpers of the reorder window with
// cumulative ack.
// ---------------------------------------------------------------------------
package rwca_pkg;

	localparam int unsigned WINDOW_SLOTS  = 32;
	localparam int unsigned SEGMENT_BYTES = 1024;
	localparam int unsigned MAX_RESULTS   = 32;

	localparam int SEQ_W    = 31;
	localparam int SIZE_W   = 11;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = $clog2(WINDOW_SLOTS);
	localparam int CNT_W    = $clog2(MAX_RESULTS + 1);

	localparam logic [STATUS_W-1:0] STAT_IN_ORDER  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_STORED    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EOF       = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_DROPPED   = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_AFTER_END = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [SEQ_W-1:0]  seq;
		logic [SIZE_W-1:0] size;
	} slot_t;

	localparam int SLOT_DATA_W = $bits(slot_t);

	// next ring position, wrapping at the window size
	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (int'(s) == int'(WINDOW_SLOTS) - 1) begin
			r = '0;
		end else begin
			r = s + SLOT_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rwca_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwca_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module rwca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/reorder_window_cumulative_ack.sv
`default_nettype none
// ---------------------------------------------------------------------------
// reorder_window_cumulative_ack
// Receiver reorder buffer: releases segments in byte order, stores early
// ones in a ring of slots and answers every segment with a cumulative ack.
//
// Usage: a segment word (seq_number, size, buffer_tag) is taken at a clock
// edge with start high and busy low. Results come out one word at a time
// with strobe high, for exactly that cycle; the receiver cannot stall.
// The first result of a segment appears in the cycle after it is taken.
// Stored, duplicate, dropped, end-of-file and after-end segments give a
// single result, and busy stays low, so a new segment may follow each cycle.
// An in-order segment that unlocks k stored slots gives 1 + k results;
// each stored slot takes a RAM read state and then an emit state, and busy
// is high during the drain (k <= 31). Slot contents sit in one RAM with a
// registered read port; slot valid bits are flops. Reset clears the
// expected number, ring base, valid bits and the end-of-file flag at once;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
module reorder_window_cumulative_ack (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rwca_pkg::SEQ_W-1:0]    seq_number,
	input  wire logic [rwca_pkg::SIZE_W-1:0]   size,
	input  wire logic [rwca_pkg::TAG_W-1:0]    buffer_tag,
	output logic                               strobe,
	output logic                               released,
	output logic [rwca_pkg::TAG_W-1:0]         release_tag,
	output logic [rwca_pkg::SEQ_W-1:0]         release_seq,
	output logic [rwca_pkg::SIZE_W-1:0]        release_size,
	output logic [rwca_pkg::SEQ_W-1:0]         ack_number,
	output logic [rwca_pkg::STATUS_W-1:0]      status,
	output logic                               last
);

	import rwca_pkg::*;

	state_t state_q, state_d;

	logic [SEQ_W-1:0]        next_exp_q;
	logic [SLOT_W-1:0]       ring_base_q;
	logic                    finished_q;
	logic [WINDOW_SLOTS-1:0] slot_valid_q;
	logic [CNT_W-1:0]        cnt_q;

	logic                strobe_q;
	logic                released_q;
	logic [TAG_W-1:0]    rel_tag_q;
	logic [SEQ_W-1:0]    rel_seq_q;
	logic [SIZE_W-1:0]   rel_size_q;
	logic [SEQ_W-1:0]    ack_q;
	logic [STATUS_W-1:0] status_q;
	logic                last_q;

	logic              accept;
	logic              is_end;
	logic              in_order;
	logic              is_later;
	logic              in_window;
	logic              do_store;
	logic [SEQ_W-1:0]  diff;
	logic [SEQ_W-1:0]  offset;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] store_slot;
	logic [SLOT_W-1:0] base_inc;
	logic [CNT_W-1:0]  cnt_next;
	logic              more;
	logic [SEQ_W-1:0]  in_size_ext;
	logic [SEQ_W-1:0]  ram_size_ext;

	logic                   ram_we;
	logic                   ram_re;
	slot_t                  wr_entry;
	logic [SLOT_DATA_W-1:0] ram_rdata;
	slot_t                  rd_entry;

	// classify the arriving segment
	always_comb begin
		accept      = start && (state_q == ST_IDLE);
		is_end      = (size == '0);
		diff        = seq_number - next_exp_q;
		offset      = SEQ_W'(diff / SEGMENT_BYTES);
		in_window   = (offset < SEQ_W'(WINDOW_SLOTS));
		in_order    = !finished_q && !is_end && (seq_number == next_exp_q);
		is_later    = !finished_q && !is_end && (seq_number > next_exp_q);
		do_store    = is_later && in_window;
		slot_sum    = {1'b0, ring_base_q} + {1'b0, offset[SLOT_W-1:0]};
		if (int'(slot_sum) >= int'(WINDOW_SLOTS)) begin
			store_slot = SLOT_W'(int'(slot_sum) - int'(WINDOW_SLOTS));
		end else begin
			store_slot = slot_sum[SLOT_W-1:0];
		end
		base_inc     = slot_inc(ring_base_q);
		in_size_ext  = {{(SEQ_W-SIZE_W){1'b0}}, size};
		rd_entry     = slot_t'(ram_rdata);
		ram_size_ext = {{(SEQ_W-SIZE_W){1'b0}}, rd_entry.size};
		cnt_next     = (state_q == ST_EMIT) ? cnt_q + CNT_W'(1) : CNT_W'(1);
		// another stored slot follows in order and the result budget allows it
		more = slot_valid_q[base_inc] && (int'(cnt_next) < int'(MAX_RESULTS))
			&& (int'(cnt_next) < int'(WINDOW_SLOTS));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_order && more) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = more ? ST_READ : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		busy   = 1'b1;
		ram_re = 1'b0;
		ram_we = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				ram_we = start && do_store;
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_EMIT: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_comb begin
		wr_entry.tag  = buffer_tag;
		wr_entry.seq  = seq_number;
		wr_entry.size = size;
	end

	rwca_ram #(
		.WIDTH(SLOT_DATA_W),
		.DEPTH(WINDOW_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(store_slot),
		.wdata(SLOT_DATA_W'(wr_entry)),
		.re   (ram_re),
		.raddr(ring_base_q),
		.rdata(ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			next_exp_q   <= '0;
			ring_base_q  <= '0;
			finished_q   <= 1'b0;
			slot_valid_q <= '0;
			cnt_q        <= '0;
			strobe_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= accept || (state_q == ST_EMIT);
			if (accept) begin
				if (!finished_q && is_end) begin
					finished_q <= 1'b1;
				end
				if (in_order) begin
					slot_valid_q[ring_base_q] <= 1'b0;
					next_exp_q  <= next_exp_q + in_size_ext;
					ring_base_q <= base_inc;
					cnt_q       <= cnt_next;
				end else if (do_store) begin
					slot_valid_q[store_slot] <= 1'b1;
				end
			end else if (state_q == ST_EMIT) begin
				slot_valid_q[ring_base_q] <= 1'b0;
				next_exp_q  <= next_exp_q + ram_size_ext;
				ring_base_q <= base_inc;
				cnt_q       <= cnt_next;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (accept) begin
			released_q <= in_order;
			rel_tag_q  <= in_order ? buffer_tag : '0;
			rel_seq_q  <= in_order ? seq_number : '0;
			rel_size_q <= in_order ? size : '0;
			last_q     <= !(in_order && more);
			if (finished_q) begin
				status_q <= STAT_AFTER_END;
				ack_q    <= next_exp_q;
			end else if (is_end) begin
				status_q <= STAT_EOF;
				ack_q    <= seq_number;
			end else if (in_order) begin
				status_q <= STAT_IN_ORDER;
				ack_q    <= next_exp_q + in_size_ext;
			end else if (do_store) begin
				status_q <= STAT_STORED;
				ack_q    <= next_exp_q;
			end else if (is_later) begin
				status_q <= STAT_DROPPED;
				ack_q    <= next_exp_q;
			end else begin
				status_q <= STAT_DUPLICATE;
				ack_q    <= next_exp_q;
			end
		end else if (state_q == ST_EMIT) begin
			status_q   <= STAT_IN_ORDER;
			released_q <= 1'b1;
			rel_tag_q  <= rd_entry.tag;
			rel_seq_q  <= rd_entry.seq;
			rel_size_q <= rd_entry.size;
			ack_q      <= next_exp_q + ram_size_ext;
			last_q     <= !more;
		end
	end

	assign strobe       = strobe_q;
	assign released     = released_q;
	assign release_tag  = rel_tag_q;
	assign release_seq  = rel_seq_q;
	assign release_size = rel_size_q;
	assign ack_number   = ack_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule
`default_nettype wire

FILE: hw/rtl/rwca_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwca_checker
// Port-level checks of the reorder buffer, bound to the top level.
// ---------------------------------------------------------------------------
module rwca_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          strobe,
	input wire logic                          released,
	input wire logic [rwca_pkg::STATUS_W-1:0] status,
	input wire logic                          last
);

	import rwca_pkg::*;

	// every accepted word answers in the very next cycle
	a_answer_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe)
		else $error("no result after accepted word");

	// a drain in progress keeps the input closed
	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("input open while results still pending");

	// only in-order releases can be followed by more results
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !released |-> last && (status != STAT_IN_ORDER))
		else $error("non-release result not final or marked in order");

	a_release_status: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && released |-> (status == STAT_IN_ORDER))
		else $error("release word with wrong status");

endmodule

bind reorder_window_cumulative_ack rwca_checker u_rwca_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.strobe  (strobe),
	.released(released),
	.status  (status),
	.last    (last)
);
`default_nettype wire

FILE: bench/rwca_ack_checker.sv
// ---------------------------------------------------------------------------
// rwca_ack_checker
// Watches the segment and result channels of the reorder window, keeps its
// own copy of the receive window and compares every result word with the
// oldest predicted one. Hands the mismatch count and the number of words
// still outstanding to the bench top.
// ---------------------------------------------------------------------------
module rwca_ack_checker
	import rwca_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic [SEQ_W-1:0]    seq_number,
	input  wire logic [SIZE_W-1:0]   size,
	input  wire logic [TAG_W-1:0]    buffer_tag,
	input  wire logic                strobe,
	input  wire logic                released,
	input  wire logic [TAG_W-1:0]    release_tag,
	input  wire logic [SEQ_W-1:0]    release_seq,
	input  wire logic [SIZE_W-1:0]   release_size,
	input  wire logic [SEQ_W-1:0]    ack_number,
	input  wire logic [STATUS_W-1:0] status,
	input  wire logic                last,
	output int                       mismatches,
	output int                       outstanding
);

	typedef struct packed {
		logic                rel;
		logic [TAG_W-1:0]    tag;
		logic [SEQ_W-1:0]    seq;
		logic [SIZE_W-1:0]   len;
		logic [SEQ_W-1:0]    ack;
		logic [STATUS_W-1:0] stat;
		logic                fin;
	} ack_word_t;

	logic [SEQ_W-1:0]  next_byte;
	logic [SLOT_W-1:0] ring_head;
	logic              held[WINDOW_SLOTS];
	slot_t             held_seg[WINDOW_SLOTS];
	logic              eof_seen;
	ack_word_t         pending_acks[$];
	int                bad = 0;

	// advance the receive window by one arriving segment
	task automatic receive_segment(input logic [SEQ_W-1:0] seq, input logic [SIZE_W-1:0] len,
			input logic [TAG_W-1:0] tag);
		ack_word_t         w;
		logic [SEQ_W-1:0]  gap;
		int unsigned       off;
		logic [SLOT_W-1:0] s;
		int                n;
		int                steps;
		if (eof_seen) begin
			pending_acks.push_back('{1'b0, '0, '0, '0, next_byte, STAT_AFTER_END, 1'b1});
		end else if (len == '0) begin
			eof_seen = 1'b1;
			pending_acks.push_back('{1'b0, '0, '0, '0, seq, STAT_EOF, 1'b1});
		end else if (seq == next_byte) begin
			held[ring_head] = 1'b0;
			next_byte = next_byte + len;
			ring_head = ring_head + 1'b1;
			w = '{1'b1, tag, seq, len, next_byte, STAT_IN_ORDER, 1'b0};
			n = 1;
			steps = 0;
			// drain stored segments that now follow in order
			while (n < MAX_RESULTS && steps < WINDOW_SLOTS - 1 && held[ring_head]) begin
				pending_acks.push_back(w);
				held[ring_head] = 1'b0;
				next_byte = next_byte + held_seg[ring_head].size;
				w = '{1'b1, held_seg[ring_head].tag, held_seg[ring_head].seq,
					held_seg[ring_head].size, next_byte, STAT_IN_ORDER, 1'b0};
				ring_head = ring_head + 1'b1;
				n++;
				steps++;
			end
			w.fin = 1'b1;
			pending_acks.push_back(w);
		end else if (seq > next_byte) begin
			gap = seq - next_byte;
			off = gap / SEGMENT_BYTES;
			if (off >= WINDOW_SLOTS) begin
				pending_acks.push_back('{1'b0, '0, '0, '0, next_byte, STAT_DROPPED, 1'b1});
			end else begin
				s = ring_head + SLOT_W'(off);
				held[s] = 1'b1;
				held_seg[s] = '{tag, seq, len};
				pending_acks.push_back('{1'b0, '0, '0, '0, next_byte, STAT_STORED, 1'b1});
			end
		end else begin
			pending_acks.push_back('{1'b0, '0, '0, '0, next_byte, STAT_DUPLICATE, 1'b1});
		end
	endtask

	task automatic compare_word;
		ack_word_t got;
		ack_word_t want;
		got = {released, release_tag, release_seq, release_size, ack_number, status, last};
		if (pending_acks.size() == 0) begin
			if (bad < 10) begin
				$display("unexpected word: rel=%0d tag=%h seq=%h size=%0d ack=%h status=%0d last=%0d",
					got.rel, got.tag, got.seq, got.len, got.ack, got.stat, got.fin);
			end
			bad++;
		end else begin
			want = pending_acks.pop_front();
			if (got.rel !== want.rel || got.tag !== want.tag || got.seq !== want.seq ||
					got.len !== want.len || got.ack !== want.ack || got.stat !== want.stat ||
					got.fin !== want.fin) begin
				if (bad < 10) begin
					$display("word mismatch at %0t", $realtime);
					$display("  exp rel=%0d tag=%h seq=%h size=%0d ack=%h status=%0d last=%0d",
						want.rel, want.tag, want.seq, want.len, want.ack, want.stat, want.fin);
					$display("  got rel=%0d tag=%h seq=%h size=%0d ack=%h status=%0d last=%0d",
						got.rel, got.tag, got.seq, got.len, got.ack, got.stat, got.fin);
				end
				bad++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_byte = '0;
			ring_head = '0;
			eof_seen = 1'b0;
			foreach (held[i]) begin
				held[i] = 1'b0;
			end
			pending_acks.delete();
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			// results belong to earlier words, so check before predicting
			if (strobe) begin
				compare_word();
			end
			if (start && !busy) begin
				receive_segment(seq_number, size, buffer_tag);
			end
			outstanding <= pending_acks.size();
			mismatches <= bad;
		end
	end

endmodule

FILE: bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Bench for the reorder window with cumulative ack. A directed opening hits
// in-order, stored, duplicate, dropped, overwritten and drained segments;
// then random windows of segments arrive in order, reversed or shuffled,
// mixed with duplicates, far-off segments and retransmissions, and the run
// ends with end of file and ignored words. A checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;
	import rwca_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [SEQ_W-1:0]    seq_number;
	logic [SIZE_W-1:0]   size;
	logic [TAG_W-1:0]    buffer_tag;
	logic                strobe;
	logic                released;
	logic [TAG_W-1:0]    release_tag;
	logic [SEQ_W-1:0]    release_seq;
	logic [SIZE_W-1:0]   release_size;
	logic [SEQ_W-1:0]    ack_number;
	logic [STATUS_W-1:0] status;
	logic                last;
	int                  mismatches;
	int                  outstanding;

	int                  words_sent;
	int                  burst_left;
	logic [SEQ_W-1:0]    stream_pos;
	logic [SEQ_W-1:0]    win_seq[WINDOW_SLOTS];
	logic [SIZE_W-1:0]   win_len[WINDOW_SLOTS];
	int                  win_order[WINDOW_SLOTS];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	reorder_window_cumulative_ack u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.seq_number   (seq_number),
		.size         (size),
		.buffer_tag   (buffer_tag),
		.strobe       (strobe),
		.released     (released),
		.release_tag  (release_tag),
		.release_seq  (release_seq),
		.release_size (release_size),
		.ack_number   (ack_number),
		.status       (status),
		.last         (last)
	);

	rwca_ack_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.seq_number   (seq_number),
		.size         (size),
		.buffer_tag   (buffer_tag),
		.strobe       (strobe),
		.released     (released),
		.release_tag  (release_tag),
		.release_seq  (release_seq),
		.release_size (release_size),
		.ack_number   (ack_number),
		.status       (status),
		.last         (last),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	// offer one segment word, hold it until taken, then maybe pause
	task automatic send_segment(input logic [SEQ_W-1:0] s, input logic [SIZE_W-1:0] z,
			input logic [TAG_W-1:0] t);
		start <= 1'b1;
		seq_number <= s;
		size <= z;
		buffer_tag <= t;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
		end
	endtask

	task automatic wait_all_acked;
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	// duplicate, far-off segment or retransmission of one already sent
	task automatic send_noise(input int k);
		int j;
		case ($urandom_range(0, 2))
			0: send_segment(SEQ_W'($urandom_range(0, stream_pos - 1)),
				SIZE_W'($urandom_range(1, 2047)), TAG_W'($urandom));
			1: send_segment(SEQ_W'($urandom_range(stream_pos + 200000, 32'h7FFF_FFFF)),
				SIZE_W'($urandom_range(1, 2047)), TAG_W'($urandom));
			default: begin
				if (k > 0) begin
					j = win_order[$urandom_range(0, k - 1)];
					send_segment(win_seq[j], win_len[j], TAG_W'($urandom));
				end else begin
					send_segment(stream_pos - 1'b1, SIZE_W'(SEGMENT_BYTES), TAG_W'($urandom));
				end
			end
		endcase
	endtask

	initial begin
		int  blen;
		int  mode;
		int  j;
		int  tmp;
		int  windows;
		bit  mid_pause;
		arst_n = 1'b0;
		start = 1'b0;
		seq_number = '0;
		size = '0;
		buffer_tag = '0;
		words_sent = 0;
		burst_left = 0;
		windows = 0;
		mid_pause = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_segment(31'd0, 11'd1024, 16'h0000);
		send_segment(31'd0, 11'd2047, 16'hFFFF);
		send_segment(31'h7FFF_FFFF, 11'd1024, 16'h5A5A);
		// first slot past the window edge
		send_segment(31'd33792, 11'd1, 16'h0001);
		// early segment in the head slot, wiped by the in-order arrival
		send_segment(31'd1524, 11'd700, 16'h1111);
		send_segment(31'd1024, 11'd1024, 16'h2222);
		send_segment(31'd5120, 11'd1024, 16'h3333);
		send_segment(31'd4096, 11'd1024, 16'h4444);
		send_segment(31'd3072, 11'd1024, 16'h5555);
		send_segment(31'd4096, 11'd1024, 16'h6666);
		send_segment(31'd2048, 11'd1024, 16'h7777);
		send_segment(31'd7168, 11'd2047, 16'h8888);
		send_segment(31'd6144, 11'd1, 16'h9999);
		wait_all_acked();
		stream_pos = 31'd8192;

		while (words_sent < 160) begin
			if (windows == 0) begin
				blen = WINDOW_SLOTS;
				mode = 1;
			end else begin
				blen = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 8);
				mode = $urandom_range(0, 2);
			end
			for (int i = 0; i < blen; i++) begin
				win_seq[i] = stream_pos + SEQ_W'(i * SEGMENT_BYTES);
				win_len[i] = (i == blen - 1) ? SIZE_W'($urandom_range(1, 2047))
					: SIZE_W'(SEGMENT_BYTES);
				win_order[i] = (mode == 1) ? blen - 1 - i : i;
			end
			if (mode == 2) begin
				for (int i = blen - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = win_order[i];
					win_order[i] = win_order[j];
					win_order[j] = tmp;
				end
			end
			for (int k = 0; k < blen; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					send_noise(k);
				end
				send_segment(win_seq[win_order[k]], win_len[win_order[k]], TAG_W'($urandom));
			end
			stream_pos = win_seq[blen - 1] + win_len[blen - 1];
			windows++;
			if (!mid_pause && words_sent >= 110) begin
				mid_pause = 1'b1;
				wait_all_acked();
			end
		end

		send_segment(SEQ_W'($urandom), '0, TAG_W'($urandom));
		send_segment(SEQ_W'($urandom), SIZE_W'($urandom_range(1, 2047)), TAG_W'($urandom));
		send_segment(stream_pos, SIZE_W'(SEGMENT_BYTES), TAG_W'($urandom));
		send_segment(SEQ_W'($urandom), '0, TAG_W'($urandom));
		wait_all_acked();
		repeat (70) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
